// ===== sv/tlc_pkg.sv =====
package tlc_pkg;

  // Cache geometry.
  localparam int unsigned SLOTS   = 16;
  localparam int unsigned SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W   = $clog2(SLOTS + 1);

  // Field widths.
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned KEY_W   = 64;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned TIME_W  = 48;
  localparam int unsigned TTL_W   = 48;
  localparam int unsigned CMP_W   = (TIME_W > TTL_W) ? TIME_W : TTL_W;

  // Register port: one 64-bit register per 8-byte word.
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned ADDR_W    = 4;
  localparam int unsigned REG_IDX_W = ADDR_W - 3;
  localparam logic [REG_IDX_W-1:0] REG_TTL = '0;

  localparam logic [TTL_W-1:0] TTL_RESET = TTL_W'(1000);

  typedef enum logic [KIND_W-1:0] {
    KIND_PUT = 2'd0,
    KIND_GET = 2'd1,
    KIND_INV = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e               kind;
    logic [KEY_W-1:0]    key;
    logic [VALUE_W-1:0]  wval;
    logic [TIME_W-1:0]   now;
  } req_t;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [TIME_W-1:0]   stamp;
    logic [VALUE_W-1:0]  value;
  } entry_t;

  typedef struct packed {
    logic                en;
    logic [SLOT_W-1:0]   idx;
    entry_t              data;
  } wr_t;

  typedef struct packed {
    logic                valid;
    logic                status;
    logic [VALUE_W-1:0]  value;
  } rslt_t;

endpackage

// ===== sv/tlc_store.sv =====
module tlc_store (
  input  logic                              clk_i,
  input  logic [tlc_pkg::SLOT_W-1:0]        rd_idx_i,
  output tlc_pkg::entry_t                   rd_data_o,
  input  tlc_pkg::wr_t                      wr_i
);

  // Key, timestamp and value of every slot, one write and one read port.
  tlc_pkg::entry_t mem_q [tlc_pkg::SLOTS];
  tlc_pkg::entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.idx] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[rd_idx_i];
  end

  assign rd_data_o = rd_q;

endmodule

// ===== sv/tlc_engine.sv =====
module tlc_engine (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              req_valid_i,
  output logic                              req_ready_o,
  input  tlc_pkg::req_t                     req_i,
  input  logic [tlc_pkg::TTL_W-1:0]         ttl_i,
  output logic [tlc_pkg::SLOT_W-1:0]        rd_idx_o,
  input  tlc_pkg::entry_t                   rd_data_i,
  output tlc_pkg::wr_t                      wr_o,
  output tlc_pkg::rslt_t                    rslt_o,
  input  logic                              rslt_ready_i
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_WRITE = 3'b100
  } state_e;

  state_e                          state_q;
  logic [tlc_pkg::CNT_W-1:0]       cnt_q;
  tlc_pkg::req_t                   req_q;
  logic [tlc_pkg::SLOTS-1:0]       valid_q;
  logic                            found_q;
  logic                            free_found_q;
  logic [tlc_pkg::SLOT_W-1:0]      match_idx_q;
  logic [tlc_pkg::TIME_W-1:0]      match_stamp_q;
  logic [tlc_pkg::VALUE_W-1:0]     match_value_q;
  logic [tlc_pkg::SLOT_W-1:0]      free_idx_q;
  logic [tlc_pkg::SLOT_W-1:0]      old_idx_q;
  logic [tlc_pkg::TIME_W-1:0]      old_stamp_q;

  logic                            accept;
  logic                            advance;
  logic                            examining;
  logic [tlc_pkg::CNT_W-1:0]       cnt_m1;
  logic [tlc_pkg::SLOT_W-1:0]      exam_idx;
  logic                            exam_valid;
  logic                            key_hit;
  logic                            older;
  logic [tlc_pkg::TIME_W-1:0]      age;
  logic                            expired;
  logic                            set_valid;
  logic                            clr_valid;

  assign req_ready_o = (state_q == ST_IDLE);
  assign accept      = req_valid_i && req_ready_o;
  assign advance     = (state_q == ST_WRITE) && rslt_ready_i;

  // The read issued for slot c returns in the next cycle, when the count is c+1.
  assign rd_idx_o   = cnt_q[tlc_pkg::SLOT_W-1:0];
  assign cnt_m1     = cnt_q - tlc_pkg::CNT_W'(1);
  assign exam_idx   = cnt_m1[tlc_pkg::SLOT_W-1:0];
  assign examining  = (state_q == ST_SCAN) && (cnt_q != '0);
  assign exam_valid = valid_q[exam_idx];

  // Shared compare unit: one key compare and one timestamp compare per slot.
  assign key_hit = exam_valid && (rd_data_i.key == req_q.key);
  assign older   = rd_data_i.stamp < old_stamp_q;

  assign age     = req_q.now - match_stamp_q;
  assign expired = tlc_pkg::CMP_W'(age) > tlc_pkg::CMP_W'(ttl_i);

  always_comb begin
    wr_o            = '0;
    wr_o.idx        = match_idx_q;
    wr_o.data.key   = req_q.key;
    wr_o.data.stamp = req_q.now;
    wr_o.data.value = req_q.wval;
    rslt_o          = '0;
    rslt_o.valid    = (state_q == ST_WRITE);
    set_valid       = 1'b0;
    clr_valid       = 1'b0;
    unique case (req_q.kind)
      tlc_pkg::KIND_PUT: begin
        wr_o.en   = advance;
        set_valid = advance;
        if (!found_q) begin
          wr_o.idx = free_found_q ? free_idx_q : old_idx_q;
        end
      end
      tlc_pkg::KIND_GET: begin
        if (!found_q) begin
          rslt_o.status = 1'b1;
        end else if (expired) begin
          rslt_o.status = 1'b1;
          clr_valid     = advance;
        end else begin
          wr_o.en         = advance;
          wr_o.data.value = match_value_q;
          rslt_o.value    = match_value_q;
        end
      end
      tlc_pkg::KIND_INV: begin
        if (found_q) begin
          wr_o.en         = advance;
          clr_valid       = advance;
          wr_o.data.stamp = match_stamp_q;
          wr_o.data.value = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_SCAN;
            cnt_q   <= '0;
          end
        end
        ST_SCAN: begin
          if (cnt_q == tlc_pkg::CNT_W'(tlc_pkg::SLOTS)) begin
            state_q <= ST_WRITE;
          end else begin
            cnt_q <= cnt_q + tlc_pkg::CNT_W'(1);
          end
        end
        ST_WRITE: begin
          if (advance) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (set_valid) begin
      valid_q[wr_o.idx] <= 1'b1;
    end else if (clr_valid) begin
      valid_q[wr_o.idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
    end else if (accept) begin
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
    end else if (examining) begin
      if (key_hit) begin
        found_q <= 1'b1;
      end
      if (!exam_valid) begin
        free_found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    if (examining) begin
      if (key_hit && !found_q) begin
        match_idx_q   <= exam_idx;
        match_stamp_q <= rd_data_i.stamp;
        match_value_q <= rd_data_i.value;
      end
      if (!exam_valid && !free_found_q) begin
        free_idx_q <= exam_idx;
      end
      if ((exam_idx == '0) || older) begin
        old_idx_q   <= exam_idx;
        old_stamp_q <= rd_data_i.stamp;
      end
    end
  end

  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_SCAN) && (cnt_q == '0))
    else $error("scan did not start from slot zero after a transfer");

  a_scan_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SCAN) && (cnt_q == tlc_pkg::CNT_W'(tlc_pkg::SLOTS)))
      |=> (state_q == ST_WRITE))
    else $error("scan did not hand over to write-back");

  a_put_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_o.en && (req_q.kind == tlc_pkg::KIND_PUT)) |=> valid_q[$past(wr_o.idx)])
    else $error("slot written by a put is not marked valid");

  a_hit_needs_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rslt_o.valid && (req_q.kind == tlc_pkg::KIND_GET) && !rslt_o.status) |-> found_q)
    else $error("get reported a hit without a matching slot");

  a_write_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (state_q == ST_IDLE) && !wr_o.en)
    else $error("write-back did not return to idle");

endmodule

// ===== sv/ttl_lru_cache.sv =====
// A request transfer produces its result in the output register after the scan and the
// write-back. The scan reads one slot per cycle through the single read port of the slot
// memory, and the block takes no new request until the write-back of the last one is done.
// Reset (rst_ni, asynchronous, active low) clears every slot's valid bit, empties the
// output register and loads the TTL register with 1000; slot contents are not cleared.
// The block is ready as soon as reset is released and takes a request at the first edge.
module ttl_lru_cache (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  // Request channel.
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [tlc_pkg::KIND_W-1:0]        kind_i,
  input  logic [tlc_pkg::KEY_W-1:0]         key_i,
  input  logic [tlc_pkg::VALUE_W-1:0]       write_value_i,
  input  logic [tlc_pkg::TIME_W-1:0]        now_ms_i,

  // Result channel.
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              status_o,
  output logic [tlc_pkg::VALUE_W-1:0]       read_value_o,

  // Register port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tlc_pkg::ADDR_W-1:0]        paddr,
  input  logic [tlc_pkg::DATA_W-1:0]        pwdata,
  output logic [tlc_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);

  // The TTL register is the only register. It sits at byte address 0; the low three
  // address bits select a byte within the 64-bit word and are not decoded.
  logic [tlc_pkg::TTL_W-1:0]      ttl_q;
  logic [tlc_pkg::REG_IDX_W-1:0]  reg_idx;
  logic                           cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[tlc_pkg::ADDR_W-1:3];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ttl_q <= tlc_pkg::TTL_RESET;
    end else if (cfg_wr && (reg_idx == tlc_pkg::REG_TTL)) begin
      ttl_q <= pwdata[tlc_pkg::TTL_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      tlc_pkg::REG_TTL: prdata = tlc_pkg::DATA_W'(ttl_q);
      default:          prdata = '0;
    endcase
  end

  // The request fields go straight to the sequencer, which captures them on the transfer.
  tlc_pkg::req_t   req;
  tlc_pkg::entry_t rd_data;
  tlc_pkg::wr_t    wr;
  tlc_pkg::rslt_t  rslt;
  logic [tlc_pkg::SLOT_W-1:0] rd_idx;
  logic            rslt_ready;

  assign req.kind = tlc_pkg::kind_e'(kind_i);
  assign req.key  = key_i;
  assign req.wval = write_value_i;
  assign req.now  = now_ms_i;

  // The sequencer scans every slot once per request, looking for the matching key,
  // the first free slot and the oldest timestamp, then performs at most one write-back.
  tlc_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (in_valid_i),
    .req_ready_o  (in_ready_o),
    .req_i        (req),
    .ttl_i        (ttl_q),
    .rd_idx_o     (rd_idx),
    .rd_data_i    (rd_data),
    .wr_o         (wr),
    .rslt_o       (rslt),
    .rslt_ready_i (rslt_ready)
  );

  tlc_store u_store (
    .clk_i     (clk_i),
    .rd_idx_i  (rd_idx),
    .rd_data_o (rd_data),
    .wr_i      (wr)
  );

  // Output register: a finished result waits here, so the sequencer can take the next
  // request while the downstream side stalls.
  logic                         out_valid_q;
  logic                         status_q;
  logic [tlc_pkg::VALUE_W-1:0]  read_value_q;
  logic                         load;

  assign rslt_ready = !out_valid_q || out_ready_i;
  assign load       = rslt.valid && rslt_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q     <= rslt.status;
      read_value_q <= rslt.value;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign read_value_o = read_value_q;

endmodule

// ===== bench/ttl_lru_cache_test.sv =====
module ttl_lru_cache_test;

  // The request kind field is two bits wide, but only three codes mean anything.
  // The fourth code must be accepted and answered with a plain success.
  localparam logic [tlc_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;

  // The TTL register sits at the first 8-byte word of the register map.
  localparam logic [tlc_pkg::ADDR_W-1:0] TTL_ADDR =
    tlc_pkg::ADDR_W'({tlc_pkg::REG_TTL, 3'b000});

  localparam int unsigned PHASES          = 6;
  localparam int unsigned ITEMS_PER_PHASE = 215;
  localparam int unsigned POOL_KEYS       = 24;
  localparam int unsigned SETTLE_CYCLES   = 30;
  // The slowest correct run is about 1350 requests, each taking the scan plus up to
  // the longest sender gap and the longest result stall. The limit below leaves
  // several times the time of that run.
  localparam int unsigned CYCLE_LIMIT     = 300000;

  typedef struct {
    logic                        status;
    logic [tlc_pkg::VALUE_W-1:0] value;
  } lookup_result_t;

  // The scoreboard keeps its own copy of the slot array and the TTL register.
  // It predicts the answer to every request that the cache accepts. It then
  // compares the cache's answers against those predictions in order.
  class cache_scoreboard;
    logic                        slot_used  [tlc_pkg::SLOTS];
    logic [tlc_pkg::KEY_W-1:0]   slot_tag   [tlc_pkg::SLOTS];
    logic [tlc_pkg::TIME_W-1:0]  slot_stamp [tlc_pkg::SLOTS];
    logic [tlc_pkg::VALUE_W-1:0] slot_data  [tlc_pkg::SLOTS];
    logic [tlc_pkg::TTL_W-1:0]   ttl_ms;
    lookup_result_t              answer_q[$];
    int unsigned                 mismatches;

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      ttl_ms     = tlc_pkg::TTL_RESET;
      mismatches = 0;
    endfunction

    function void report(string detail);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", detail);
    endfunction

    function void set_ttl(logic [tlc_pkg::TTL_W-1:0] value);
      ttl_ms = value;
    endfunction

    function int unsigned pending();
      return answer_q.size();
    endfunction

    function int unsigned match_slot(logic [tlc_pkg::KEY_W-1:0] key);
      for (int unsigned i = 0; i < tlc_pkg::SLOTS; i++)
        if (slot_used[i] && slot_tag[i] == key) return i;
      return tlc_pkg::SLOTS;
    endfunction

    function void note_request(logic [tlc_pkg::KIND_W-1:0] kind,
                               logic [tlc_pkg::KEY_W-1:0] key,
                               logic [tlc_pkg::VALUE_W-1:0] wval,
                               logic [tlc_pkg::TIME_W-1:0] now);
      lookup_result_t             res;
      int unsigned                hit;
      int unsigned                victim;
      logic [tlc_pkg::TIME_W-1:0] age;
      res.status = 1'b0;
      res.value  = '0;
      hit = match_slot(key);
      if (kind == tlc_pkg::KIND_PUT) begin
        if (hit < tlc_pkg::SLOTS) begin
          // The entry is rewritten where it stands.
          slot_data[hit]  = wval;
          slot_stamp[hit] = now;
        end else begin
          victim = 0;
          while (victim < tlc_pkg::SLOTS && slot_used[victim]) victim++;
          if (victim == tlc_pkg::SLOTS) begin
            // Every slot is full. Pick the smallest raw stamp, which is not
            // the same as the largest age. The first such slot wins a tie.
            victim = 0;
            for (int unsigned i = 1; i < tlc_pkg::SLOTS; i++)
              if (slot_stamp[i] < slot_stamp[victim]) victim = i;
          end
          slot_used[victim]  = 1'b1;
          slot_tag[victim]   = key;
          slot_stamp[victim] = now;
          slot_data[victim]  = wval;
        end
      end else if (kind == tlc_pkg::KIND_GET) begin
        if (hit == tlc_pkg::SLOTS) begin
          res.status = 1'b1;
        end else begin
          age = now - slot_stamp[hit];
          if (age > ttl_ms) begin
            slot_used[hit] = 1'b0;
            res.status     = 1'b1;
          end else begin
            slot_stamp[hit] = now;
            res.value       = slot_data[hit];
          end
        end
      end else if (kind == tlc_pkg::KIND_INV) begin
        if (hit < tlc_pkg::SLOTS) begin
          slot_used[hit] = 1'b0;
          slot_data[hit] = '0;
        end
      end
      answer_q.push_back(res);
    endfunction

    function void check_result(logic status, logic [tlc_pkg::VALUE_W-1:0] value);
      lookup_result_t want;
      if (answer_q.size() == 0) begin
        report($sformatf("result with nothing outstanding: status %b value %h",
                         status, value));
        return;
      end
      want = answer_q.pop_front();
      if (status !== want.status)
        report($sformatf("status expected %b, got %b", want.status, status));
      if (value !== want.value)
        report($sformatf("read_value expected %h, got %h", want.value, value));
    endfunction
  endclass

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic [tlc_pkg::KIND_W-1:0]  kind_i;
  logic [tlc_pkg::KEY_W-1:0]   key_i;
  logic [tlc_pkg::VALUE_W-1:0] write_value_i;
  logic [tlc_pkg::TIME_W-1:0]  now_ms_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic                        status_o;
  logic [tlc_pkg::VALUE_W-1:0] read_value_o;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [tlc_pkg::ADDR_W-1:0]  paddr;
  logic [tlc_pkg::DATA_W-1:0]  pwdata;
  logic [tlc_pkg::DATA_W-1:0]  prdata;
  logic                        pready;

  cache_scoreboard board = new();
  int unsigned     cycle_count = 0;
  // In the last phase, neither side of the cache idles.
  bit              quiet_tail = 1'b0;

  ttl_lru_cache dut (.*);

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // Both channels are watched at the rising edge, before the cache's own
  // registers update. The result side is checked first. A result can never
  // belong to a request whose transfer happens at the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) board.check_result(status_o, read_value_o);
      if (in_valid_i && in_ready_o)
        board.note_request(kind_i, key_i, write_value_i, now_ms_i);
    end
  end

  // The result ready line alternates between stall bursts and open runs of
  // random length. It stays high once the quiet tail begins.
  initial begin : result_sink
    int unsigned span;
    forever begin
      if (!quiet_tail && $urandom_range(0, 2) == 0) begin
        out_ready_i = 1'b0;
        span        = $urandom_range(1, 10);
      end else begin
        out_ready_i = 1'b1;
        span        = $urandom_range(1, 20);
      end
      repeat (span) @(negedge clk_i);
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // All driving tasks start and end at a falling edge. A request keeps valid
  // high when it returns, so that a request sent right after it follows
  // without a gap.
  task automatic send_request(input logic [tlc_pkg::KIND_W-1:0] kind,
                              input logic [tlc_pkg::KEY_W-1:0] key,
                              input logic [tlc_pkg::VALUE_W-1:0] wval,
                              input logic [tlc_pkg::TIME_W-1:0] now);
    kind_i        = kind;
    key_i         = key;
    write_value_i = wval;
    now_ms_i      = now;
    in_valid_i    = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic pause_sender(input int unsigned cycles);
    in_valid_i = 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i = 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
  endtask

  task automatic write_ttl(input logic [tlc_pkg::DATA_W-1:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = TTL_ADDR;
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    // Only the low TTL_W bits of the write data are kept.
    board.set_ttl(data[tlc_pkg::TTL_W-1:0]);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic read_ttl();
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = TTL_ADDR;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[tlc_pkg::TTL_W-1:0] !== board.ttl_ms)
      board.report($sformatf("ttl readback expected %h, got %h",
                             board.ttl_ms, prdata[tlc_pkg::TTL_W-1:0]));
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  initial begin : stimulus
    logic [tlc_pkg::KEY_W-1:0]   key_pool [POOL_KEYS];
    logic [tlc_pkg::TIME_W-1:0]  now;
    logic [tlc_pkg::TTL_W-1:0]   ttl_next;
    logic [tlc_pkg::KIND_W-1:0]  kind;
    logic [tlc_pkg::KEY_W-1:0]   key;
    int unsigned                 tick_max;
    int unsigned                 pick;

    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    kind_i        = tlc_pkg::KIND_PUT;
    key_i         = '0;
    write_value_i = '0;
    now_ms_i      = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // The TTL register must come out of reset at its default value.
    read_ttl();

    // Directed part. This runs under the default TTL of 1000 ms.
    // A get on an empty cache misses.
    send_request(tlc_pkg::KIND_GET, '0, '1, '0);
    send_request(tlc_pkg::KIND_PUT, '0, '1, '0);
    // An age equal to the TTL still counts as live.
    send_request(tlc_pkg::KIND_GET, '0, '0, 48'd1000);
    send_request(tlc_pkg::KIND_PUT, '1, '0, 48'd1000);
    // One millisecond past the TTL, the entry expires. It is then gone.
    send_request(tlc_pkg::KIND_GET, '1, '1, 48'd2001);
    send_request(tlc_pkg::KIND_GET, '1, '0, 48'd2001);
    // A put on a present key overwrites that entry in place.
    send_request(tlc_pkg::KIND_PUT, '0, 64'h0123_4567_89ab_cdef, 48'd2000);
    send_request(tlc_pkg::KIND_GET, '0, '0, 48'd2000);
    send_request(tlc_pkg::KIND_INV, '0, '1, 48'd2000);
    send_request(tlc_pkg::KIND_GET, '0, '0, 48'd2000);
    // An invalidate of an absent key still succeeds.
    send_request(tlc_pkg::KIND_INV, {32{2'b01}}, '0, 48'd2000);
    send_request(KIND_SPARE, '0, '1, '1);
    // The age is taken modulo the time width. With the stamp at the maximum
    // time, an age of exactly the TTL is reached after wraparound.
    send_request(tlc_pkg::KIND_PUT, {32{2'b10}}, {32{2'b01}}, '1);
    send_request(tlc_pkg::KIND_GET, {32{2'b10}}, '0, 48'd999);
    send_request(tlc_pkg::KIND_GET, {32{2'b10}}, '0, 48'd2000);

    // Each random phase rewrites the TTL while the cache is idle. Extreme TTL
    // values are included. Every phase uses a fresh pool of keys, a few more
    // than there are slots, so that hits, overwrites and evictions all occur.
    // Some keys in the pool differ from another key in only one bit.
    for (int unsigned p = 0; p < PHASES; p++) begin
      drain_results();
      case (p)
        0: begin
          ttl_next = '0;
          tick_max = 1;
          now      = tlc_pkg::TIME_W'({$urandom, $urandom});
        end
        1: begin
          ttl_next = '1;
          tick_max = 1 << 20;
          now      = '1 - tlc_pkg::TIME_W'($urandom_range(0, 1 << 26));
        end
        2: begin
          ttl_next = 48'd300;
          tick_max = 100;
          now      = tlc_pkg::TIME_W'({$urandom, $urandom});
        end
        3: begin
          ttl_next = tlc_pkg::TTL_W'($urandom_range(1, 5000));
          tick_max = $urandom_range(1, 1200);
          now      = tlc_pkg::TIME_W'({$urandom, $urandom});
        end
        4: begin
          // The time wraps during this phase, so eviction sees small raw
          // stamps on the newest entries.
          ttl_next = 48'd20;
          tick_max = 8;
          now      = '1 - tlc_pkg::TIME_W'(400);
        end
        default: begin
          ttl_next   = 48'd64;
          tick_max   = 20;
          now        = tlc_pkg::TIME_W'({$urandom, $urandom});
          quiet_tail = 1'b1;
        end
      endcase
      // Junk in the upper word bits must be dropped by the register.
      write_ttl({16'($urandom), ttl_next});
      read_ttl();

      for (int unsigned i = 0; i < POOL_KEYS; i++) begin
        if (i > 0 && $urandom_range(0, 2) == 0)
          key_pool[i] = key_pool[$urandom_range(0, i - 1)] ^ (64'd1 << $urandom_range(0, 63));
        else
          key_pool[i] = {$urandom, $urandom};
      end

      for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (!quiet_tail && $urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 10));
        // Halfway through one phase, the sender holds off until every
        // answer is back.
        if (p == 2 && n == ITEMS_PER_PHASE / 2) drain_results();
        if ($urandom_range(0, 39) == 0)
          now = tlc_pkg::TIME_W'({$urandom, $urandom});
        else
          now = now + tlc_pkg::TIME_W'($urandom_range(0, tick_max));
        pick = $urandom_range(0, 99);
        if (pick < 42)      kind = tlc_pkg::KIND_PUT;
        else if (pick < 84) kind = tlc_pkg::KIND_GET;
        else if (pick < 96) kind = tlc_pkg::KIND_INV;
        else                kind = KIND_SPARE;
        if ($urandom_range(0, 6) == 0) key = {$urandom, $urandom};
        else                           key = key_pool[$urandom_range(0, POOL_KEYS - 1)];
        send_request(kind, key, {$urandom, $urandom}, now);
      end
    end

    // Wait for the last answers, then give a stray result time to appear.
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
